### sv/ptlk_pkg.sv
// ----------------------------------------------------------------------------
// ptlk_pkg
// Shared types, codes and constants of the planar three-link arm kinematics
// block: CORDIC step angles, request structs and command/register codes.
// ----------------------------------------------------------------------------
package ptlk_pkg;

    // Commands
    localparam logic CMD_FWD = 1'b0;
    localparam logic CMD_INV = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINK_ONE   = 2'd0;
    localparam logic [1:0] CFG_LINK_TWO   = 2'd1;
    localparam logic [1:0] CFG_LINK_THREE = 2'd2;

    localparam logic [15:0] LINK_ONE_RST   = 16'd19661;
    localparam logic [15:0] LINK_TWO_RST   = 16'd19661;
    localparam logic [15:0] LINK_THREE_RST = 16'd6554;

    // CORDIC datapath width and constants (angles: 2^32 per turn)
    localparam int CRD_W = 52;
    localparam logic signed [CRD_W-1:0] K_GAIN = 52'sd652032874;
    localparam logic signed [33:0] QUARTER_Z = 34'sd1073741824;
    localparam logic signed [33:0] HALF_Z    = 34'sd2147483648;

    localparam int ATAN_LEN = 24;
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Number of steps of the shared divide / square-root unit
    localparam int DS_STEPS = 31;

    typedef struct packed {
        logic start;
        logic vec;      // 1: vectoring (atan2), 0: rotation (sin/cos)
    } t_crd_req;

    typedef struct packed {
        logic start;
        logic sqrt;     // 1: square root, 0: division
    } t_ds_req;

    // atan(2^-idx) rounded to a multiple of 2^(32-abits)
    function automatic logic [31:0] step_angle(input logic [4:0] idx, input int abits);
        logic [32:0] t;
        int s;
        s = 32 - abits;
        if (idx < 5'(ATAN_LEN)) begin
            t = {1'b0, ATAN_TAB[idx]};
        end else begin
            t = '0;
        end
        t = ((t >> (s - 1)) + 33'd1) >> 1;
        t = t << s;
        return t[31:0];
    endfunction

endpackage

### sv/ptlk_cordic.sv
// ----------------------------------------------------------------------------
// ptlk_cordic
// Shared iterative CORDIC: rotation mode gives Q30 cosine/sine of a binary
// angle, vectoring mode gives atan2(y, x). One micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ptlk_cordic #(
    parameter int ITERS      = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ptlk_pkg::t_crd_req                   i_req,
    input  logic [31:0]                          i_ang,
    input  logic signed [ptlk_pkg::CRD_W-1:0]    i_x,
    input  logic signed [ptlk_pkg::CRD_W-1:0]    i_y,
    output logic                                 o_done,
    output logic signed [ptlk_pkg::CRD_W-1:0]    o_x,
    output logic signed [ptlk_pkg::CRD_W-1:0]    o_y,
    output logic [31:0]                          o_z
);

    logic                              r_busy;
    logic                              r_done;
    logic [4:0]                        r_cnt;
    logic                              r_vec;
    logic                              r_neg;
    logic                              r_zero;
    logic signed [ptlk_pkg::CRD_W-1:0] r_x;
    logic signed [ptlk_pkg::CRD_W-1:0] r_y;
    logic signed [33:0]                r_z;

    logic signed [ptlk_pkg::CRD_W-1:0] n_x0;
    logic signed [ptlk_pkg::CRD_W-1:0] n_y0;
    logic signed [33:0]                n_z0;
    logic                              n_neg0;
    logic                              n_zero0;

    logic signed [ptlk_pkg::CRD_W-1:0] dx;
    logic signed [ptlk_pkg::CRD_W-1:0] dy;
    logic [33:0]                       step_t;
    logic                              up;

    // start-up: fold into +-90 degrees, or quarter-turn pre-rotation for x < 0
    always_comb begin
        n_x0    = ptlk_pkg::K_GAIN;
        n_y0    = '0;
        n_z0    = 34'($signed(i_ang));
        n_neg0  = 1'b0;
        n_zero0 = 1'b0;
        if (i_req.vec) begin
            n_x0    = i_x;
            n_y0    = i_y;
            n_z0    = '0;
            n_zero0 = (i_x == '0) && (i_y == '0);
            if (i_x[ptlk_pkg::CRD_W-1]) begin
                if (!i_y[ptlk_pkg::CRD_W-1]) begin
                    n_x0 = i_y;
                    n_y0 = -i_x;
                    n_z0 = ptlk_pkg::QUARTER_Z;
                end else begin
                    n_x0 = -i_y;
                    n_y0 = i_x;
                    n_z0 = -ptlk_pkg::QUARTER_Z;
                end
            end
        end else begin
            if (n_z0 > ptlk_pkg::QUARTER_Z) begin
                n_z0   = n_z0 - ptlk_pkg::HALF_Z;
                n_neg0 = 1'b1;
            end else if (n_z0 < -ptlk_pkg::QUARTER_Z) begin
                n_z0   = n_z0 + ptlk_pkg::HALF_Z;
                n_neg0 = 1'b1;
            end
        end
    end

    always_comb begin
        dx     = r_y >>> r_cnt;
        dy     = r_x >>> r_cnt;
        step_t = 34'(ptlk_pkg::step_angle(r_cnt, ANGLE_BITS));
        up     = r_vec ? !(r_y > 52'sd0) : !r_z[33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_vec  <= i_req.vec;
            r_x    <= n_x0;
            r_y    <= n_y0;
            r_z    <= n_z0;
            r_neg  <= n_neg0;
            r_zero <= n_zero0;
        end else if (r_busy) begin
            if (up) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - step_t;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + step_t;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_neg ? -r_x : r_x;
    assign o_y    = r_neg ? -r_y : r_y;
    assign o_z    = r_zero ? 32'd0 : r_z[31:0];

endmodule

### sv/ptlk_divsqrt.sv
// ----------------------------------------------------------------------------
// ptlk_divsqrt
// Shared bit-serial unit: restoring division (quotient below 2^31, high half
// of the dividend already below the divisor) or integer square root of a
// value up to 2^60. One result bit per cycle.
// ----------------------------------------------------------------------------
module ptlk_divsqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptlk_pkg::t_ds_req  i_req,
    input  logic [62:0]        i_a,
    input  logic [31:0]        i_d,
    output logic               o_done,
    output logic [30:0]        o_q
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic        r_sqrt;
    logic [61:0] r_rem;
    logic [60:0] r_r;
    logic [30:0] r_low;
    logic [31:0] r_d;
    logic [30:0] r_q;

    logic [32:0] div_tr;
    logic        div_ge;
    logic [60:0] sq_bit;
    logic [61:0] sq_tr;
    logic        sq_ge;

    always_comb begin
        div_tr = {r_rem[31:0], r_low[30]};
        div_ge = div_tr >= {1'b0, r_d};
        sq_bit = 61'd1 << (6'd60 - {r_cnt, 1'b0});
        sq_tr  = {1'b0, r_r} + {1'b0, sq_bit};
        sq_ge  = r_rem >= sq_tr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(ptlk_pkg::DS_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt;
            r_d    <= i_d;
            r_q    <= '0;
            r_r    <= '0;
            r_low  <= i_a[30:0];
            if (i_req.sqrt) begin
                r_rem <= {1'b0, i_a[60:0]};
            end else begin
                r_rem <= {30'd0, i_a[62:31]};
            end
        end else if (r_busy) begin
            if (r_sqrt) begin
                if (sq_ge) begin
                    r_rem <= r_rem - sq_tr;
                    r_r   <= (r_r >> 1) + sq_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
            end else begin
                r_low <= r_low << 1;
                r_q   <= {r_q[29:0], div_ge};
                if (div_ge) begin
                    r_rem <= {29'd0, div_tr - {1'b0, r_d}};
                end else begin
                    r_rem <= {29'd0, div_tr};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_sqrt ? r_r[30:0] : r_q;

endmodule

### sv/planar_three_link_kinematics_top.sv
// ----------------------------------------------------------------------------
// planar_three_link_kinematics_top
// Forward and inverse kinematics of a planar arm with three revolute links,
// sequenced over a shared CORDIC, a shared divide/sqrt unit and one multiplier.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+----------------------
//  command   | in        | start && !busy               | i_cmd, joints, target
//  result    | out       | o_strobe, one cycle          | tool, solution, flags
//  config    | in        | i_cfg_valid && o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  Forward item: three sin/cos passes, one per link.
//  Inverse item: bound by the six CORDIC passes, divisor normalisation and the
//  two 31-step divide and square-root runs. Unreachable targets finish after
//  the check.
//  busy is high from the accepting edge until the last result is issued.
//  Synchronous active-low reset; link lengths return to their defaults.
//  Results cannot be stalled; config is always ready.
// ----------------------------------------------------------------------------
module planar_three_link_kinematics_top #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_BITS        = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic signed [15:0] i_joint_angle_one,
    input  logic signed [15:0] i_joint_angle_two,
    input  logic signed [15:0] i_joint_angle_three,
    input  logic signed [17:0] i_target_x,
    input  logic signed [17:0] i_target_y,
    input  logic signed [15:0] i_target_orient,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_strobe,
    output logic signed [17:0] o_tool_x,
    output logic signed [17:0] o_tool_y,
    output logic signed [15:0] o_tool_orient,
    output logic signed [15:0] o_sol_angle_one,
    output logic signed [15:0] o_sol_angle_two,
    output logic signed [15:0] o_sol_angle_three,
    output logic               o_elbow_branch,
    output logic               o_unreachable,
    output logic               o_last
);

    localparam int NST = 36;

    typedef enum logic [NST-1:0] {
        ST_IDLE   = 36'd1 << 0,
        ST_F_CRD  = 36'd1 << 1,
        ST_F_CWT  = 36'd1 << 2,
        ST_F_MC   = 36'd1 << 3,
        ST_F_MS   = 36'd1 << 4,
        ST_F_ACC  = 36'd1 << 5,
        ST_F_OUT  = 36'd1 << 6,
        ST_I_CRD  = 36'd1 << 7,
        ST_I_CWT  = 36'd1 << 8,
        ST_I_M3C  = 36'd1 << 9,
        ST_I_M3S  = 36'd1 << 10,
        ST_I_WY   = 36'd1 << 11,
        ST_I_WXX  = 36'd1 << 12,
        ST_I_WYY  = 36'd1 << 13,
        ST_I_L11  = 36'd1 << 14,
        ST_I_L22  = 36'd1 << 15,
        ST_I_L12  = 36'd1 << 16,
        ST_I_DEN  = 36'd1 << 17,
        ST_I_CHK  = 36'd1 << 18,
        ST_I_NORM = 36'd1 << 19,
        ST_I_DIV  = 36'd1 << 20,
        ST_I_DWT  = 36'd1 << 21,
        ST_I_CSQ  = 36'd1 << 22,
        ST_I_SQ   = 36'd1 << 23,
        ST_I_SWT  = 36'd1 << 24,
        ST_I_VB   = 36'd1 << 25,
        ST_I_VBW  = 36'd1 << 26,
        ST_I_VE   = 36'd1 << 27,
        ST_I_VEW  = 36'd1 << 28,
        ST_I_PY   = 36'd1 << 29,
        ST_I_PX   = 36'd1 << 30,
        ST_I_VXY  = 36'd1 << 31,
        ST_I_VS   = 36'd1 << 32,
        ST_I_VSW  = 36'd1 << 33,
        ST_I_OUT  = 36'd1 << 34,
        ST_I_UR   = 36'd1 << 35
    } t_state;

    t_state r_state;
    t_state n_state;

    // link lengths
    logic [15:0] r_l1;
    logic [15:0] r_l2;
    logic [15:0] r_l3;

    // item and working registers
    logic signed [15:0] r_ja2;
    logic signed [15:0] r_ja3;
    logic signed [17:0] r_tx;
    logic signed [17:0] r_ty;
    logic [31:0]        r_ang;
    logic [1:0]         r_k;
    logic               r_b;
    logic signed [31:0] r_c;
    logic signed [31:0] r_s;
    logic signed [63:0] r_prod;
    logic signed [57:0] r_accx;
    logic signed [57:0] r_accy;
    logic signed [27:0] r_wx;
    logic signed [27:0] r_wy;
    logic [49:0]        r_d;
    logic [55:0]        r_mag;
    logic signed [31:0] r_c2;
    logic [30:0]        r_s2;
    logic [31:0]        r_base;
    logic [31:0]        r_th1;
    logic [31:0]        r_th2;
    logic signed [51:0] r_vx;
    logic signed [51:0] r_vy;
    logic               r_strobe;

    // multiplier operands
    logic signed [31:0] m_a;
    logic signed [31:0] m_b;
    logic [15:0]        lk;
    logic signed [31:0] sg;

    // shared units
    ptlk_pkg::t_crd_req                crd_req;
    logic signed [ptlk_pkg::CRD_W-1:0] crd_x_in;
    logic signed [ptlk_pkg::CRD_W-1:0] crd_y_in;
    logic                              crd_done;
    logic signed [ptlk_pkg::CRD_W-1:0] crd_x;
    logic signed [ptlk_pkg::CRD_W-1:0] crd_y;
    logic [31:0]                       crd_z;

    ptlk_pkg::t_ds_req ds_req;
    logic [62:0]       ds_a;
    logic              ds_done;
    logic [30:0]       ds_q;

    function automatic logic [17:0] pos_out(input logic signed [57:0] a);
        logic signed [57:0] s;
        logic signed [27:0] v;
        s = a + 58'sd536870912;
        v = 28'(s >>> 30);
        if (v > 28'sd131071) begin
            return 18'h1FFFF;
        end else if (v < -28'sd131072) begin
            return 18'h20000;
        end
        return v[17:0];
    endfunction

    function automatic logic [15:0] ang_out(input logic [31:0] a);
        logic [31:0] t;
        t = a + 32'h0000_8000;
        return t[31:16];
    endfunction

    // target*2^30 - L3*trig, rounded to 8 fraction bits
    function automatic logic signed [27:0] wrist_pos(input logic signed [17:0] t,
                                                     input logic signed [63:0] p);
        logic [49:0] s;
        s = (50'(t) <<< 30) - p[49:0] + 50'd2097152;
        return s[49:22];
    endfunction

    ptlk_cordic #(
        .ITERS      (CORDIC_ITERATIONS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (crd_req),
        .i_ang   (r_ang),
        .i_x     (crd_x_in),
        .i_y     (crd_y_in),
        .o_done  (crd_done),
        .o_x     (crd_x),
        .o_y     (crd_y),
        .o_z     (crd_z)
    );

    ptlk_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .i_a     (ds_a),
        .i_d     (r_d[31:0]),
        .o_done  (ds_done),
        .o_q     (ds_q)
    );

    assign sg = r_b ? -$signed({1'b0, r_s2}) : $signed({1'b0, r_s2});

    always_comb begin
        case (r_k)
            2'd0:    lk = r_l1;
            2'd1:    lk = r_l2;
            default: lk = r_l3;
        endcase
    end

    // operand selection for the shared multiplier
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            ST_F_MC:  begin m_a = $signed({16'd0, lk}); m_b = r_c; end
            ST_F_MS:  begin m_a = $signed({16'd0, lk}); m_b = r_s; end
            ST_I_M3C: begin m_a = $signed({16'd0, r_l3}); m_b = r_c; end
            ST_I_M3S: begin m_a = $signed({16'd0, r_l3}); m_b = r_s; end
            ST_I_WXX: begin m_a = 32'(r_wx); m_b = 32'(r_wx); end
            ST_I_WYY: begin m_a = 32'(r_wy); m_b = 32'(r_wy); end
            ST_I_L11: begin m_a = $signed({16'd0, r_l1}); m_b = $signed({16'd0, r_l1}); end
            ST_I_L22: begin m_a = $signed({16'd0, r_l2}); m_b = $signed({16'd0, r_l2}); end
            ST_I_L12: begin m_a = $signed({16'd0, r_l1}); m_b = $signed({16'd0, r_l2}); end
            ST_I_CSQ: begin m_a = r_c2; m_b = r_c2; end
            ST_I_PY:  begin m_a = $signed({16'd0, r_l2}); m_b = sg; end
            ST_I_PX:  begin m_a = $signed({16'd0, r_l2}); m_b = r_c2; end
            default:  begin m_a = '0; m_b = '0; end
        endcase
    end

    // requests to the shared units
    always_comb begin
        crd_req  = '0;
        crd_x_in = '0;
        crd_y_in = '0;
        ds_req   = '0;
        ds_a     = '0;
        unique case (r_state)
            ST_F_CRD, ST_I_CRD: crd_req.start = 1'b1;
            ST_I_VB: begin
                crd_req  = '{start: 1'b1, vec: 1'b1};
                crd_x_in = 52'(r_wx);
                crd_y_in = 52'(r_wy);
            end
            ST_I_VE: begin
                crd_req  = '{start: 1'b1, vec: 1'b1};
                crd_x_in = 52'(r_c2);
                crd_y_in = 52'(sg);
            end
            ST_I_VS: begin
                crd_req  = '{start: 1'b1, vec: 1'b1};
                crd_x_in = r_vx;
                crd_y_in = r_vy;
            end
            ST_I_DIV: begin
                ds_req.start = 1'b1;
                ds_a = 63'({r_mag[31:0], 30'd0}) + 63'(r_d[31:1]);
            end
            ST_I_SQ: begin
                ds_req = '{start: 1'b1, sqrt: 1'b1};
                ds_a   = (63'd1 << 60) - r_prod[62:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_cmd == ptlk_pkg::CMD_INV) ? ST_I_CRD : ST_F_CRD;
                end
            end
            ST_F_CRD:  n_state = ST_F_CWT;
            ST_F_CWT:  if (crd_done) n_state = ST_F_MC;
            ST_F_MC:   n_state = ST_F_MS;
            ST_F_MS:   n_state = ST_F_ACC;
            ST_F_ACC:  n_state = (r_k == 2'd2) ? ST_F_OUT : ST_F_CRD;
            ST_F_OUT:  n_state = ST_IDLE;
            ST_I_CRD:  n_state = ST_I_CWT;
            ST_I_CWT:  if (crd_done) n_state = ST_I_M3C;
            ST_I_M3C:  n_state = ST_I_M3S;
            ST_I_M3S:  n_state = ST_I_WY;
            ST_I_WY:   n_state = ST_I_WXX;
            ST_I_WXX:  n_state = ST_I_WYY;
            ST_I_WYY:  n_state = ST_I_L11;
            ST_I_L11:  n_state = ST_I_L22;
            ST_I_L22:  n_state = ST_I_L12;
            ST_I_L12:  n_state = ST_I_DEN;
            ST_I_DEN:  n_state = ST_I_CHK;
            ST_I_CHK: begin
                if ((r_d == '0) || (r_mag > 56'(r_d))) begin
                    n_state = ST_I_UR;
                end else begin
                    n_state = ST_I_NORM;
                end
            end
            ST_I_NORM: if (r_d[49:32] == '0) n_state = ST_I_DIV;
            ST_I_DIV:  n_state = ST_I_DWT;
            ST_I_DWT:  if (ds_done) n_state = ST_I_CSQ;
            ST_I_CSQ:  n_state = ST_I_SQ;
            ST_I_SQ:   n_state = ST_I_SWT;
            ST_I_SWT:  if (ds_done) n_state = ST_I_VB;
            ST_I_VB:   n_state = ST_I_VBW;
            ST_I_VBW:  if (crd_done) n_state = ST_I_VE;
            ST_I_VE:   n_state = ST_I_VEW;
            ST_I_VEW:  if (crd_done) n_state = ST_I_PY;
            ST_I_PY:   n_state = ST_I_PX;
            ST_I_PX:   n_state = ST_I_VXY;
            ST_I_VXY:  n_state = ST_I_VS;
            ST_I_VS:   n_state = ST_I_VSW;
            ST_I_VSW:  if (crd_done) n_state = ST_I_OUT;
            ST_I_OUT:  n_state = r_b ? ST_IDLE : ST_I_VE;
            ST_I_UR:   n_state = r_b ? ST_IDLE : ST_I_UR;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control state and link registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_l1     <= ptlk_pkg::LINK_ONE_RST;
            r_l2     <= ptlk_pkg::LINK_TWO_RST;
            r_l3     <= ptlk_pkg::LINK_THREE_RST;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_F_OUT) || (r_state == ST_I_OUT) ||
                        (r_state == ST_I_UR);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ptlk_pkg::CFG_LINK_ONE:   r_l1 <= i_cfg_data;
                    ptlk_pkg::CFG_LINK_TWO:   r_l2 <= i_cfg_data;
                    ptlk_pkg::CFG_LINK_THREE: r_l3 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        unique case (r_state)
            ST_IDLE: begin
                r_ja2  <= i_joint_angle_two;
                r_ja3  <= i_joint_angle_three;
                r_tx   <= i_target_x;
                r_ty   <= i_target_y;
                r_k    <= 2'd0;
                r_b    <= 1'b0;
                r_accx <= '0;
                r_accy <= '0;
                if (i_cmd == ptlk_pkg::CMD_INV) begin
                    r_ang <= {i_target_orient, 16'd0};
                end else begin
                    r_ang <= {i_joint_angle_one, 16'd0};
                end
            end
            ST_F_CWT, ST_I_CWT: begin
                if (crd_done) begin
                    r_c <= crd_x[31:0];
                    r_s <= crd_y[31:0];
                end
            end
            ST_F_MS:  r_accx <= r_accx + r_prod[57:0];
            ST_F_ACC: begin
                r_accy <= r_accy + r_prod[57:0];
                r_k    <= r_k + 2'd1;
                // last link: the angle already holds the sum of all three
                if (r_k == 2'd0) begin
                    r_ang <= r_ang + {r_ja2, 16'd0};
                end else if (r_k == 2'd1) begin
                    r_ang <= r_ang + {r_ja3, 16'd0};
                end
            end
            ST_F_OUT: begin
                o_tool_x          <= $signed(pos_out(r_accx));
                o_tool_y          <= $signed(pos_out(r_accy));
                o_tool_orient     <= $signed(r_ang[31:16]);
                o_sol_angle_one   <= '0;
                o_sol_angle_two   <= '0;
                o_sol_angle_three <= '0;
                o_elbow_branch    <= 1'b0;
                o_unreachable     <= 1'b0;
                o_last            <= 1'b1;
            end
            ST_I_M3S: r_wx <= wrist_pos(r_tx, r_prod);
            ST_I_WY:  r_wy <= wrist_pos(r_ty, r_prod);
            ST_I_WYY: r_accx <= r_prod[57:0];
            ST_I_L11: r_accx <= r_accx + r_prod[57:0];
            ST_I_L22, ST_I_L12: r_accx <= r_accx - {r_prod[41:0], 16'd0};
            ST_I_DEN: begin
                r_d   <= {r_prod[32:0], 17'd0};
                r_mag <= r_accx[57] ? 56'(-r_accx) : r_accx[55:0];
            end
            ST_I_NORM: begin
                // halve both until the divisor fits 32 bits
                if (r_d[49:32] != '0) begin
                    r_d   <= r_d >> 1;
                    r_mag <= r_mag >> 1;
                end
            end
            ST_I_DWT: begin
                if (ds_done) begin
                    r_c2 <= r_accx[57] ? -$signed({1'b0, ds_q}) : $signed({1'b0, ds_q});
                end
            end
            ST_I_SWT: if (ds_done) r_s2 <= ds_q;
            ST_I_VBW: if (crd_done) r_base <= crd_z;
            ST_I_VEW: if (crd_done) r_th2 <= crd_z;
            ST_I_PX:  r_vy <= r_prod[51:0];
            ST_I_VXY: r_vx <= (52'(r_l1) << 30) + r_prod[51:0];
            ST_I_VSW: if (crd_done) r_th1 <= r_base - crd_z;
            ST_I_OUT: begin
                o_tool_x          <= '0;
                o_tool_y          <= '0;
                o_tool_orient     <= '0;
                o_sol_angle_one   <= $signed(ang_out(r_th1));
                o_sol_angle_two   <= $signed(ang_out(r_th2));
                o_sol_angle_three <= $signed(ang_out(r_ang - (r_th1 + r_th2)));
                o_elbow_branch    <= r_b;
                o_unreachable     <= 1'b0;
                o_last            <= r_b;
                r_b               <= 1'b1;
            end
            ST_I_UR: begin
                o_tool_x          <= '0;
                o_tool_y          <= '0;
                o_tool_orient     <= '0;
                o_sol_angle_one   <= '0;
                o_sol_angle_two   <= '0;
                o_sol_angle_three <= '0;
                o_elbow_branch    <= r_b;
                o_unreachable     <= 1'b1;
                o_last            <= r_b;
                r_b               <= 1'b1;
            end
            default: ;
        endcase
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;

endmodule

### sv/ptlk_checker.sv
// ----------------------------------------------------------------------------
// ptlk_checker
// Port-level checks of the kinematics block, bound to the top level.
// ----------------------------------------------------------------------------
module ptlk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input logic signed [17:0] o_tool_x,
    input logic signed [17:0] o_tool_y,
    input logic signed [15:0] o_tool_orient,
    input logic signed [15:0] o_sol_angle_one,
    input logic signed [15:0] o_sol_angle_two,
    input logic signed [15:0] o_sol_angle_three,
    input logic               o_elbow_branch,
    input logic               o_unreachable,
    input logic               o_last
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("busy or strobe after reset");

    a_branch_last: assert property (@(posedge i_clk)
        o_strobe && o_elbow_branch |-> o_last)
        else $error("negative elbow item not marked last");

    a_unreach_zero: assert property (@(posedge i_clk)
        o_strobe && o_unreachable |->
            o_sol_angle_one == 16'sd0 && o_sol_angle_two == 16'sd0 &&
            o_sol_angle_three == 16'sd0)
        else $error("unreachable item carries angles");

    a_first_inverse: assert property (@(posedge i_clk)
        o_strobe && !o_last |->
            !o_elbow_branch && o_tool_x == 18'sd0 && o_tool_y == 18'sd0 &&
            o_tool_orient == 16'sd0)
        else $error("non-final item is not a positive elbow solution");

endmodule

bind planar_three_link_kinematics_top ptlk_checker u_ptlk_checker (.*);

### test/planar_three_link_kinematics_top_tb.sv
// ----------------------------------------------------------------------------
// planar_three_link_kinematics_top_tb
// Self-checking bench: forward and inverse commands, directed corner cases and
// random items over several link-length settings, each result checked against
// a bit-exact fixed-point predictor held in the bench.
// ----------------------------------------------------------------------------
module planar_three_link_kinematics_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint QTR  = 64'sd1073741824;
    localparam longint HLF  = 64'sd2147483648;
    localparam longint KG   = 64'sd652032874;
    localparam int     NITER = 16;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [17:0] tool_x;
        logic signed [17:0] tool_y;
        logic signed [15:0] tool_orient;
        logic signed [15:0] sol_one;
        logic signed [15:0] sol_two;
        logic signed [15:0] sol_three;
        logic               branch;
        logic               unreach;
        logic               last;
    } t_pose;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cmd = ptlk_pkg::CMD_FWD;
    logic signed [15:0] i_joint_angle_one = '0;
    logic signed [15:0] i_joint_angle_two = '0;
    logic signed [15:0] i_joint_angle_three = '0;
    logic signed [17:0] i_target_x = '0;
    logic signed [17:0] i_target_y = '0;
    logic signed [15:0] i_target_orient = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               o_strobe;
    logic signed [17:0] o_tool_x;
    logic signed [17:0] o_tool_y;
    logic signed [15:0] o_tool_orient;
    logic signed [15:0] o_sol_angle_one;
    logic signed [15:0] o_sol_angle_two;
    logic signed [15:0] o_sol_angle_three;
    logic               o_elbow_branch;
    logic               o_unreachable;
    logic               o_last;

    planar_three_link_kinematics_top dut (.*);

    t_pose       pose_q[$];
    int          n_errors = 0;
    logic [15:0] len_one = ptlk_pkg::LINK_ONE_RST;
    logic [15:0] len_two = ptlk_pkg::LINK_TWO_RST;
    logic [15:0] len_three = ptlk_pkg::LINK_THREE_RST;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

    // ---------------- fixed-point arm model ----------------
    function automatic longint step_ang(int i);
        longint t;
        t = longint'(ptlk_pkg::ATAN_TAB[i]);
        t = ((t >> 15) + 1) >> 1;
        return t << 16;
    endfunction

    function automatic void rot_sincos(input logic [31:0] ang,
                                       output longint c, output longint s);
        longint z, x, y, dx, dy;
        logic neg;
        z = {{32{ang[31]}}, ang};
        x = KG;
        y = 0;
        neg = 1'b0;
        if (z > QTR) begin
            z -= HLF; neg = 1'b1;
        end else if (z < -QTR) begin
            z += HLF; neg = 1'b1;
        end
        for (int i = 0; i < NITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= step_ang(i);
            end else begin
                x += dx; y -= dy; z += step_ang(i);
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic logic [31:0] vec_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 32'd0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = QTR;
            end else begin
                x = -y; y = t; z = -QTR;
            end
        end
        for (int i = 0; i < NITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += step_ang(i);
            end else begin
                x -= dx; y += dy; z -= step_ang(i);
            end
        end
        return z[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] round_ang(logic [31:0] a);
        logic [31:0] t;
        t = a + 32'h8000;
        return t[31:16];
    endfunction

    function automatic logic [17:0] round_pos(longint q);
        longint v;
        v = (q + (64'sd1 <<< 29)) >>> 30;
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v[17:0];
    endfunction

    function automatic t_pose tool_pose(logic [15:0] j1, logic [15:0] j2, logic [15:0] j3);
        t_pose p;
        logic [31:0] a1, a12, a123;
        longint c1, s1, c2, s2, c3, s3, l1, l2, l3;
        l1 = longint'(len_one); l2 = longint'(len_two); l3 = longint'(len_three);
        a1 = {j1, 16'h0};
        a12 = a1 + {j2, 16'h0};
        a123 = a12 + {j3, 16'h0};
        rot_sincos(a1, c1, s1);
        rot_sincos(a12, c2, s2);
        rot_sincos(a123, c3, s3);
        p = '{default: '0};
        p.tool_x = round_pos(l1 * c1 + l2 * c2 + l3 * c3);
        p.tool_y = round_pos(l1 * s1 + l2 * s2 + l3 * s3);
        p.tool_orient = a123[31:16];
        p.last = 1'b1;
        return p;
    endfunction

    task automatic push_arm_solutions(logic signed [17:0] px, logic signed [17:0] py,
                                      logic [15:0] orient);
        t_pose p[2];
        longint l1, l2, l3, cp, sp, wx, wy, num, den, c2, s2, sg;
        logic [63:0] mag, d;
        logic [31:0] phi, base, th1, th2;
        l1 = longint'(len_one); l2 = longint'(len_two); l3 = longint'(len_three);
        phi = {orient, 16'h0};
        p[0] = '{default: '0};
        p[1] = '{default: '0};
        p[1].branch = 1'b1;
        p[1].last = 1'b1;
        rot_sincos(phi, cp, sp);
        wx = (longint'(px) * QTR - l3 * cp + (64'sd1 <<< 21)) >>> 22;
        wy = (longint'(py) * QTR - l3 * sp + (64'sd1 <<< 21)) >>> 22;
        num = wx * wx + wy * wy - (l1 * l1 + l2 * l2) * 65536;
        den = 2 * l1 * l2 * 65536;
        mag = (num < 0) ? -num : num;
        d = den;
        if (d == 0 || mag > d) begin
            p[0].unreach = 1'b1;
            p[1].unreach = 1'b1;
        end else begin
            while (d >= (64'd1 << 32)) begin
                d >>= 1; mag >>= 1;
            end
            c2 = (mag * (64'd1 << 30) + d / 2) / d;
            if (num < 0) c2 = -c2;
            s2 = int_sqrt((64'd1 << 60) - 64'(c2 * c2));
            base = vec_angle(wy, wx);
            for (int b = 0; b < 2; b++) begin
                sg = b ? -s2 : s2;
                th2 = vec_angle(sg, c2);
                th1 = base - vec_angle(l2 * sg, l1 * QTR + l2 * c2);
                p[b].sol_one = round_ang(th1);
                p[b].sol_two = round_ang(th2);
                p[b].sol_three = round_ang(phi - (th1 + th2));
            end
        end
        pose_q.push_back(p[0]);
        pose_q.push_back(p[1]);
    endtask

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n && o_strobe) begin
            if (pose_q.size() == 0) begin
                $error("result with no item outstanding");
                n_errors++;
            end else begin
                e = pose_q.pop_front();
                if (o_tool_x !== e.tool_x) begin
                    $error("tool_x exp %0d got %0d", e.tool_x, o_tool_x); n_errors++;
                end
                if (o_tool_y !== e.tool_y) begin
                    $error("tool_y exp %0d got %0d", e.tool_y, o_tool_y); n_errors++;
                end
                if (o_tool_orient !== e.tool_orient) begin
                    $error("tool_orient exp %0d got %0d", e.tool_orient, o_tool_orient);
                    n_errors++;
                end
                if (o_sol_angle_one !== e.sol_one) begin
                    $error("sol_angle_one exp %0d got %0d", e.sol_one, o_sol_angle_one);
                    n_errors++;
                end
                if (o_sol_angle_two !== e.sol_two) begin
                    $error("sol_angle_two exp %0d got %0d", e.sol_two, o_sol_angle_two);
                    n_errors++;
                end
                if (o_sol_angle_three !== e.sol_three) begin
                    $error("sol_angle_three exp %0d got %0d", e.sol_three, o_sol_angle_three);
                    n_errors++;
                end
                if (o_elbow_branch !== e.branch) begin
                    $error("elbow_branch exp %0b got %0b", e.branch, o_elbow_branch);
                    n_errors++;
                end
                if (o_unreachable !== e.unreach) begin
                    $error("unreachable exp %0b got %0b", e.unreach, o_unreachable);
                    n_errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0b got %0b", e.last, o_last); n_errors++;
                end
            end
        end
    end

    // ---------------- drivers ----------------
    task automatic send_item(logic cmd, logic [15:0] j1, logic [15:0] j2, logic [15:0] j3,
                             logic [17:0] px, logic [17:0] py, logic [15:0] orient);
        int gap;
        start <= 1'b1;
        i_cmd <= cmd;
        i_joint_angle_one <= j1;
        i_joint_angle_two <= j2;
        i_joint_angle_three <= j3;
        i_target_x <= px;
        i_target_y <= py;
        i_target_orient <= orient;
        do @(posedge i_clk); while (busy);
        if (cmd == ptlk_pkg::CMD_FWD) pose_q.push_back(tool_pose(j1, j2, j3));
        else push_arm_solutions(px, py, orient);
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pose_q.size() != 0 || busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ptlk_pkg::CFG_LINK_ONE:   len_one = val;
            ptlk_pkg::CFG_LINK_TWO:   len_two = val;
            ptlk_pkg::CFG_LINK_THREE: len_three = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_links(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        drain();
        write_reg(ptlk_pkg::CFG_LINK_ONE, a);
        write_reg(ptlk_pkg::CFG_LINK_TWO, b);
        write_reg(ptlk_pkg::CFG_LINK_THREE, c);
    endtask

    // ---------------- tests ----------------
    task automatic test_forward_corners();
        send_item(ptlk_pkg::CMD_FWD, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0);
        send_item(ptlk_pkg::CMD_FWD, 16'h8000, 16'h8000, 16'h8000, '1, '1, '1);
        send_item(ptlk_pkg::CMD_FWD, 16'h7FFF, 16'h7FFF, 16'h7FFF, '0, '0, '0);
        send_item(ptlk_pkg::CMD_FWD, 16'h4000, 16'hC000, 16'hFFFF, '0, '0, '0);
        send_item(ptlk_pkg::CMD_FWD, 16'h2000, 16'h0001, 16'h8001, '0, '0, '0);
    endtask

    task automatic test_inverse_corners();
        t_pose p;
        p = tool_pose(16'h1000, 16'h2000, 16'hE000);
        send_item(ptlk_pkg::CMD_INV, '0, '0, '0, p.tool_x, p.tool_y, p.tool_orient);
        // fully stretched and folded arm
        p = tool_pose(16'h0000, 16'h0000, 16'h0000);
        send_item(ptlk_pkg::CMD_INV, '0, '0, '0, p.tool_x, p.tool_y, p.tool_orient);
        p = tool_pose(16'h3000, 16'h8000, 16'h8000);
        send_item(ptlk_pkg::CMD_INV, '0, '0, '0, p.tool_x, p.tool_y, p.tool_orient);
        // wrist on the origin
        send_item(ptlk_pkg::CMD_INV, '0, '0, '0, 18'(len_three), 18'd0, 16'h0000);
        send_item(ptlk_pkg::CMD_INV, '0, '0, '0, 18'h1FFFF, 18'h1FFFF, 16'h7FFF);
        send_item(ptlk_pkg::CMD_INV, '0, '0, '0, 18'h20000, 18'h20000, 16'h8000);
        send_item(ptlk_pkg::CMD_INV, '0, '0, '0, 18'h00000, 18'h00000, 16'h0000);
        send_item(ptlk_pkg::CMD_INV, '0, '0, '0, 18'h20000, 18'h1FFFF, 16'hFFFF);
    endtask

    task automatic test_unused_register();
        drain();
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_item(ptlk_pkg::CMD_FWD, 16'h1234, 16'h4321, 16'hABCD, '0, '0, '0);
        send_item(ptlk_pkg::CMD_INV, '0, '0, '0, 18'd20000, 18'd15000, 16'h1000);
    endtask

    task automatic test_random(int n);
        t_pose p;
        logic [15:0] j1, j2, j3;
        for (int k = 0; k < n; k++) begin
            j1 = 16'($urandom); j2 = 16'($urandom); j3 = 16'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2: send_item(ptlk_pkg::CMD_FWD, j1, j2, j3, 18'($urandom),
                                   18'($urandom), 16'($urandom));
                3, 4: send_item(ptlk_pkg::CMD_INV, j1, j2, j3, 18'($urandom),
                                18'($urandom), 16'($urandom));
                default: begin
                    // target the arm can reach, random unused fields
                    p = tool_pose(j1, j2, j3);
                    send_item(ptlk_pkg::CMD_INV, 16'($urandom), 16'($urandom),
                              16'($urandom), p.tool_x, p.tool_y, p.tool_orient);
                end
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_forward_corners();
        test_inverse_corners();
        test_random(300);
        drain();    // sender holds off until nothing is outstanding
        test_random(200);

        set_links(16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_forward_corners();
        test_inverse_corners();
        test_random(300);

        // zero link lengths: no inverse solution exists
        set_links(16'h0000, 16'h0000, 16'h0000);
        test_inverse_corners();
        test_random(100);
        set_links(16'h0000, 16'h4000, 16'h1000);
        test_random(60);

        test_unused_register();

        set_links(16'd300, 16'd7000, 16'd50);
        test_random(300);
        for (int ph = 0; ph < 3; ph++) begin
            set_links(16'($urandom), 16'($urandom), 16'($urandom));
            test_random(230);
        end
        set_links(16'd40000, 16'd12000, 16'd0);
        test_inverse_corners();
        test_random(100);

        drain();
        repeat (300) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
sv/ptlk_pkg.sv
sv/ptlk_cordic.sv
sv/ptlk_divsqrt.sv
sv/planar_three_link_kinematics_top.sv
sv/ptlk_checker.sv
test/planar_three_link_kinematics_top_tb.sv
